>>> src/hcw_relative_orbit_propagator_core_defines.svh
// Assertion macros used by the core RTL file.
`ifndef HCW_RELATIVE_ORBIT_PROPAGATOR_CORE_DEFINES_SVH
`define HCW_RELATIVE_ORBIT_PROPAGATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HCW_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed");
`define HCW_CHECK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define HCW_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define HCW_CHECK(lbl, cond)
`define HCW_CHECK_IMPL(lbl, ante, cons)
`define HCW_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/hcwop_pkg.sv
`default_nettype none
package hcwop_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TRIG_FRAC   = 30;
  localparam int MOTION_FRAC = 32;
  localparam int ANG_LSB     = 64 + FRAC_BITS;
  localparam int TW          = 34;
  localparam int TERM_W      = 58;

  localparam logic [56:0] TERM_LIM = 57'(1) << 56;
  localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic [31:0] INV2PI_LO = INV2PI_Q64[31:0];
  localparam logic [31:0] INV2PI_HI = INV2PI_Q64[63:32];
  localparam logic signed [33:0] TWOPI_Q30 = 34'sd6746518852;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic signed [33:0] QPI_Q30   = 34'sd843314857;
  localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
  localparam logic [31:0] OCTANT_HALF = 32'h2000_0000;

  localparam logic [2:0] REG_MEAN_MOTION  = 3'd0;
  localparam logic [2:0] REG_RECIP_MOTION = 3'd1;
  localparam logic [2:0] REG_INIT_POS_R   = 3'd2;
  localparam logic [2:0] REG_INIT_POS_I   = 3'd3;
  localparam logic [2:0] REG_INIT_POS_C   = 3'd4;
  localparam logic [2:0] REG_INIT_VEL_R   = 3'd5;
  localparam logic [2:0] REG_INIT_VEL_I   = 3'd6;
  localparam logic [2:0] REG_INIT_VEL_C   = 3'd7;

  typedef logic signed [TW-1:0] trig_t;

  typedef struct packed {
    logic              bad;
    logic [1:0]        qd;
    logic signed [47:0] t;
    logic [47:0]       nt;
  } side_t;

  typedef struct packed {
    logic signed [47:0] pos_r;
    logic signed [47:0] pos_i;
    logic signed [47:0] pos_c;
    logic signed [47:0] vel_r;
    logic signed [47:0] vel_i;
    logic signed [47:0] vel_c;
    logic               status;
  } res_t;

  // Restoring shift-and-subtract quotient of two non-negative constants.
  function automatic longint shift_div(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & longint'(1));
      if (r >= den) begin
        r = r - den;
        q = q | (longint'(1) << b);
      end
    end
    return q;
  endfunction

  function automatic trig_t atan_q30(input int i);
    longint sum;
    longint term;
    int     k;
    int     e;
    sum = 0;
    if (i == 0) begin
      return QPI_Q30;
    end
    for (k = 0; k < 32; k++) begin
      e = 60 - (2 * k + 1) * i;
      if (e >= 0) begin
        term = shift_div(longint'(1) << e, longint'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
    end
    return TW'((sum + (longint'(1) << 29)) >>> 30);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -64'sh0000_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

endpackage
`default_nettype wire

>>> src/hcwop_mulr.sv
`default_nettype none
module hcwop_mulr #(
  parameter int AW = 49,
  parameter int BW = 49,
  parameter int SH = 30
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [AW-1:0]                        a,
  input  wire logic [BW-1:0]                        b,
  output logic signed [hcwop_pkg::TERM_W-1:0]       p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;
  localparam int WW = (PW + 1 > hcwop_pkg::TERM_W) ? PW + 1 : hcwop_pkg::TERM_W;

  logic [AW-1:0]    ma1;
  logic [BW-1:0]    mb1;
  logic             neg1, neg2, neg3;
  logic [AL+BL-1:0] ll2;
  logic [AL+BH-1:0] lh2;
  logic [AH+BL-1:0] hl2;
  logic [AH+BH-1:0] hh2;
  logic [PW-1:0]    prod3;
  logic [WW-1:0]    rnd;
  logic [56:0]      mag;

  always_comb begin
    rnd = (WW'(prod3) + (WW'(1) << (SH - 1))) >> SH;
    mag = (rnd > WW'(hcwop_pkg::TERM_LIM)) ? hcwop_pkg::TERM_LIM : rnd[56:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[AW-1] ^ b[BW-1];
      ma1 <= a[AW-1] ? AW'(-a) : a;
      mb1 <= b[BW-1] ? BW'(-b) : b;
      neg2 <= neg1;
      ll2 <= {{BL{1'b0}}, ma1[AL-1:0]} * {{AL{1'b0}}, mb1[BL-1:0]};
      lh2 <= {{BH{1'b0}}, ma1[AL-1:0]} * {{AL{1'b0}}, mb1[BW-1:BL]};
      hl2 <= {{BL{1'b0}}, ma1[AW-1:AL]} * {{AH{1'b0}}, mb1[BL-1:0]};
      hh2 <= {{BH{1'b0}}, ma1[AW-1:AL]} * {{AH{1'b0}}, mb1[BW-1:BL]};
      neg3 <= neg2;
      prod3 <= PW'(ll2) + (PW'(lh2) << BL) + (PW'(hl2) << AL) + (PW'(hh2) << (AL + BL));
      p <= neg3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

>>> src/hcwop_cordic_cell.sv
`default_nettype none
module hcwop_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire hcwop_pkg::trig_t        x_in,
  input  wire hcwop_pkg::trig_t        y_in,
  input  wire hcwop_pkg::trig_t        z_in,
  input  wire hcwop_pkg::side_t        side_in,
  output hcwop_pkg::trig_t             x_out,
  output hcwop_pkg::trig_t             y_out,
  output hcwop_pkg::trig_t             z_out,
  output hcwop_pkg::side_t             side_out
);

  localparam hcwop_pkg::trig_t AT = hcwop_pkg::atan_q30(IDX);

  hcwop_pkg::trig_t dx, dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (!z_in[hcwop_pkg::TW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - AT;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + AT;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/hcw_relative_orbit_propagator_core.sv
// Clohessy-Wiltshire closed-form relative orbit propagator.
// Configuration: write mean_motion, recip_motion and the six initial state
// components through cfg_valid/cfg_ready/cfg_index/cfg_data while the block
// is idle. cfg_ready is always high, so every beat is taken at once.
// Input: one time_offset beat per cycle on in_valid/in_stall, unless in_stall
// is high. Output: one beat per input on out_valid/out_stall carrying
// position, velocity and status. The rate is one beat per cycle while the
// pipeline is not frozen, set by the fully pipelined angle reduction, the
// chain of CORDIC cells and the two ranks of pipelined multipliers.
// When the receiver stalls, one more result lands in a skid register and the
// whole pipeline then freezes, raising in_stall until the skid drains.
// A zero mean motion or a negative time gives status 1 and zero state.
// Synchronous reset clears config and valid registers and drops beats in flight.
`default_nettype none
`include "hcw_relative_orbit_propagator_core_defines.svh"
module hcw_relative_orbit_propagator_core #(
  parameter int TRIG_STAGES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [47:0] time_offset,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      pos_r,
  output logic signed [47:0]      pos_i,
  output logic signed [47:0]      pos_c,
  output logic signed [47:0]      vel_r,
  output logic signed [47:0]      vel_i,
  output logic signed [47:0]      vel_c,
  output logic                    status
);

  localparam int VL = TRIG_STAGES + 20;
  localparam int RW = hcwop_pkg::TERM_W;

  logic [31:0]        mean_motion;
  logic [47:0]        recip_motion;
  logic signed [47:0] x0, y0, z0, xd0, yd0, zd0;

  logic          en;
  logic [VL-1:0] vld;
  logic          skid_full;
  hcwop_pkg::res_t fin, outr, skid;

  assign cfg_ready = 1'b1;
  assign en = !skid_full;
  assign in_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_motion <= '0;
      recip_motion <= '0;
      x0 <= '0;
      y0 <= '0;
      z0 <= '0;
      xd0 <= '0;
      yd0 <= '0;
      zd0 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hcwop_pkg::REG_MEAN_MOTION:  mean_motion <= cfg_data[31:0];
        hcwop_pkg::REG_RECIP_MOTION: recip_motion <= cfg_data;
        hcwop_pkg::REG_INIT_POS_R:   x0 <= cfg_data;
        hcwop_pkg::REG_INIT_POS_I:   y0 <= cfg_data;
        hcwop_pkg::REG_INIT_POS_C:   z0 <= cfg_data;
        hcwop_pkg::REG_INIT_VEL_R:   xd0 <= cfg_data;
        hcwop_pkg::REG_INIT_VEL_I:   yd0 <= cfg_data;
        hcwop_pkg::REG_INIT_VEL_C:   zd0 <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VL-2:0], in_valid};
    end
  end

  // Angle reduction: n*t, then the turn fraction of n*t/(2*pi).
  logic [63:0]  na1;
  logic [47:0]  nb1;
  logic [79:0]  p2;
  logic [63:0]  pp00, pp01, pp10, pp11;
  logic [47:0]  pp20, pp21;
  logic [97:0]  l4;
  logic [81:0]  h4;
  logic [143:0] full;
  logic [31:0]  u5, uq, rv;
  logic [79:0]  ntw;
  logic signed [47:0] t1, t2, t3, t4, t5;
  logic         bad1, bad2, bad3, bad4, bad5;
  logic [47:0]  nt3, nt4, nt5;
  logic signed [31:0] res6;
  hcwop_pkg::side_t side6;
  hcwop_pkg::side_t sd_z [0:3];
  logic signed [RW-1:0] zp;

  assign ntw = (p2 + (80'(1) << (hcwop_pkg::MOTION_FRAC - 1))) >> hcwop_pkg::MOTION_FRAC;
  assign full = 144'(l4) + (144'(h4) << 64);
  assign uq = u5 + hcwop_pkg::OCTANT_HALF;
  assign rv = u5 - {uq[31:30], 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= time_offset;
      bad1 <= (mean_motion == '0) || time_offset[47];
      na1 <= {32'b0, mean_motion} * {32'b0, time_offset[31:0]};
      nb1 <= {16'b0, mean_motion} * {32'b0, time_offset[47:32]};
      t2 <= t1;
      bad2 <= bad1;
      p2 <= {16'b0, na1} + {nb1, 32'b0};
      t3 <= t2;
      bad3 <= bad2;
      nt3 <= ntw[47:0];
      pp00 <= {32'b0, p2[31:0]} * {32'b0, hcwop_pkg::INV2PI_LO};
      pp01 <= {32'b0, p2[31:0]} * {32'b0, hcwop_pkg::INV2PI_HI};
      pp10 <= {32'b0, p2[63:32]} * {32'b0, hcwop_pkg::INV2PI_LO};
      pp11 <= {32'b0, p2[63:32]} * {32'b0, hcwop_pkg::INV2PI_HI};
      pp20 <= {32'b0, p2[79:64]} * {16'b0, hcwop_pkg::INV2PI_LO};
      pp21 <= {32'b0, p2[79:64]} * {16'b0, hcwop_pkg::INV2PI_HI};
      t4 <= t3;
      bad4 <= bad3;
      nt4 <= nt3;
      l4 <= 98'(pp00) + (98'(pp01) << 32) + (98'(pp10) << 32);
      h4 <= 82'(pp11) + 82'(pp20) + (82'(pp21) << 32);
      t5 <= t4;
      bad5 <= bad4;
      nt5 <= nt4;
      u5 <= full[hcwop_pkg::ANG_LSB+31:hcwop_pkg::ANG_LSB];
      side6.bad <= bad5;
      side6.qd <= uq[31:30];
      side6.t <= t5;
      side6.nt <= nt5;
      res6 <= $signed(rv);
      sd_z[0] <= side6;
      for (int k = 1; k < 4; k++) begin
        sd_z[k] <= sd_z[k-1];
      end
    end
  end

  hcwop_mulr #(.AW(32), .BW(hcwop_pkg::TW), .SH(hcwop_pkg::MOTION_FRAC)) u_zmul (
    .clk(clk), .en(en), .a(res6), .b(hcwop_pkg::TWOPI_Q30), .p(zp)
  );

  // CORDIC chain.
  hcwop_pkg::trig_t cx [0:TRIG_STAGES];
  hcwop_pkg::trig_t cy [0:TRIG_STAGES];
  hcwop_pkg::trig_t cz [0:TRIG_STAGES];
  hcwop_pkg::side_t cs [0:TRIG_STAGES];

  assign cx[0] = hcwop_pkg::GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = zp[hcwop_pkg::TW-1:0];
  assign cs[0] = sd_z[3];

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    hcwop_cordic_cell #(.IDX(g)) u_cell (
      .clk(clk), .en(en),
      .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]), .side_in(cs[g]),
      .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1]), .side_out(cs[g+1])
    );
  end

  hcwop_pkg::trig_t s_n, c_n, s_m, c_m, omc_m;
  hcwop_pkg::side_t m_side;

  always_comb begin
    unique case (cs[TRIG_STAGES].qd)
      2'd0: begin
        c_n = cx[TRIG_STAGES];
        s_n = cy[TRIG_STAGES];
      end
      2'd1: begin
        c_n = -cy[TRIG_STAGES];
        s_n = cx[TRIG_STAGES];
      end
      2'd2: begin
        c_n = -cx[TRIG_STAGES];
        s_n = -cy[TRIG_STAGES];
      end
      default: begin
        c_n = cy[TRIG_STAGES];
        s_n = -cx[TRIG_STAGES];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_m <= s_n;
      c_m <= c_n;
      omc_m <= hcwop_pkg::ONE_Q30 - c_n;
      m_side <= cs[TRIG_STAGES];
    end
  end

  // First rank of products.
  logic [48:0] l1a [0:13];
  logic [48:0] l1b [0:13];
  logic signed [RW-1:0] l1p [0:13];
  logic [48:0] rn49, n49, s49, c49, omc49, nt49, t49;
  logic [48:0] x049, y049, z049, xd049, yd049, zd049;

  always_comb begin
    rn49 = {1'b0, recip_motion};
    n49 = {17'b0, mean_motion};
    s49 = {{15{s_m[hcwop_pkg::TW-1]}}, s_m};
    c49 = {{15{c_m[hcwop_pkg::TW-1]}}, c_m};
    omc49 = {{15{omc_m[hcwop_pkg::TW-1]}}, omc_m};
    nt49 = {1'b0, m_side.nt};
    t49 = {m_side.t[47], m_side.t};
    x049 = {x0[47], x0};
    y049 = {y0[47], y0};
    z049 = {z0[47], z0};
    xd049 = {xd0[47], xd0};
    yd049 = {yd0[47], yd0};
    zd049 = {zd0[47], zd0};
    l1a[0] = rn49;   l1b[0] = s49;
    l1a[1] = rn49;   l1b[1] = omc49;
    l1a[2] = n49;    l1b[2] = s49;
    l1a[3] = n49;    l1b[3] = omc49;
    l1a[4] = c49;    l1b[4] = x049;
    l1a[5] = s49;    l1b[5] = x049;
    l1a[6] = nt49;   l1b[6] = x049;
    l1a[7] = t49;    l1b[7] = yd049;
    l1a[8] = c49;    l1b[8] = z049;
    l1a[9] = c49;    l1b[9] = xd049;
    l1a[10] = s49;   l1b[10] = yd049;
    l1a[11] = s49;   l1b[11] = xd049;
    l1a[12] = c49;   l1b[12] = yd049;
    l1a[13] = c49;   l1b[13] = zd049;
  end

  for (genvar g = 0; g < 14; g++) begin : g_l1
    localparam int SH = (g == 2 || g == 3) ? hcwop_pkg::MOTION_FRAC :
                        (g == 6 || g == 7) ? hcwop_pkg::FRAC_BITS : hcwop_pkg::TRIG_FRAC;
    hcwop_mulr #(.AW(49), .BW(49), .SH(SH)) u_mul (
      .clk(clk), .en(en), .a(l1a[g]), .b(l1b[g]), .p(l1p[g])
    );
  end

  // Second rank of products.
  logic [48:0] l2b [0:7];
  logic [RW-1:0] l2a [0:7];
  logic signed [RW-1:0] l2p [0:7];

  always_comb begin
    l2a[0] = l1p[0];  l2b[0] = xd049;
    l2a[1] = l1p[1];  l2b[1] = yd049;
    l2a[2] = l1p[1];  l2b[2] = xd049;
    l2a[3] = l1p[0];  l2b[3] = yd049;
    l2a[4] = l1p[0];  l2b[4] = zd049;
    l2a[5] = l1p[2];  l2b[5] = x049;
    l2a[6] = l1p[3];  l2b[6] = x049;
    l2a[7] = l1p[2];  l2b[7] = z049;
  end

  for (genvar g = 0; g < 8; g++) begin : g_l2
    localparam int SH = (g < 5) ? hcwop_pkg::FRAC_BITS : hcwop_pkg::TRIG_FRAC;
    hcwop_mulr #(.AW(RW), .BW(49), .SH(SH)) u_mul (
      .clk(clk), .en(en), .a(l2a[g]), .b(l2b[g]), .p(l2p[g])
    );
  end

  logic signed [RW-1:0] l1d [0:3][4:13];
  logic [7:0] bad_d;

  always_ff @(posedge clk) begin
    if (en) begin
      bad_d <= {bad_d[6:0], m_side.bad};
      for (int g = 4; g < 14; g++) begin
        l1d[0][g] <= l1p[g];
        for (int k = 1; k < 4; k++) begin
          l1d[k][g] <= l1d[k-1][g];
        end
      end
    end
  end

  // Final sums.
  logic signed [63:0] e1 [4:13];
  logic signed [63:0] e2 [0:7];
  logic signed [63:0] ex0, ey0, eyd0;
  logic signed [63:0] v [0:5];
  hcwop_pkg::res_t fin_n;

  always_comb begin
    for (int g = 4; g < 14; g++) begin
      e1[g] = {{(64-RW){l1d[3][g][RW-1]}}, l1d[3][g]};
    end
    for (int g = 0; g < 8; g++) begin
      e2[g] = {{(64-RW){l2p[g][RW-1]}}, l2p[g]};
    end
    ex0 = {{16{x0[47]}}, x0};
    ey0 = {{16{y0[47]}}, y0};
    eyd0 = {{16{yd0[47]}}, yd0};
    v[0] = 64'sd4 * ex0 - 64'sd3 * e1[4] + e2[0] + 64'sd2 * e2[1];
    v[1] = ey0 + 64'sd6 * e1[5] - 64'sd6 * e1[6] - 64'sd2 * e2[2]
           + 64'sd4 * e2[3] - 64'sd3 * e1[7];
    v[2] = e1[8] + e2[4];
    v[3] = 64'sd3 * e2[5] + e1[9] + 64'sd2 * e1[10];
    v[4] = -64'sd6 * e2[6] - 64'sd2 * e1[11] + 64'sd4 * e1[12] - 64'sd3 * eyd0;
    v[5] = e1[13] - e2[7];
    if (bad_d[7]) begin
      fin_n = '0;
      fin_n.status = 1'b1;
    end else begin
      fin_n.pos_r = hcwop_pkg::sat48(v[0]);
      fin_n.pos_i = hcwop_pkg::sat48(v[1]);
      fin_n.pos_c = hcwop_pkg::sat48(v[2]);
      fin_n.vel_r = hcwop_pkg::sat48(v[3]);
      fin_n.vel_i = hcwop_pkg::sat48(v[4]);
      fin_n.vel_c = hcwop_pkg::sat48(v[5]);
      fin_n.status = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_n;
    end
  end

  // Output register and skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (en) begin
      if (out_valid && out_stall) begin
        if (vld[VL-1]) begin
          skid_full <= 1'b1;
        end
      end else begin
        out_valid <= vld[VL-1];
      end
    end else if (!out_stall) begin
      out_valid <= 1'b1;
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_valid && out_stall) begin
        if (vld[VL-1]) begin
          skid <= fin;
        end
      end else begin
        outr <= fin;
      end
    end else if (!out_stall) begin
      outr <= skid;
    end
  end

  assign pos_r = outr.pos_r;
  assign pos_i = outr.pos_i;
  assign pos_c = outr.pos_c;
  assign vel_r = outr.vel_r;
  assign vel_i = outr.vel_i;
  assign vel_c = outr.vel_c;
  assign status = outr.status;

  `HCW_CHECK(a_skid_has_out, skid_full |-> out_valid)
  `HCW_CHECK_NEXT(a_skid_fills, out_valid && out_stall && !skid_full && vld[VL-1], skid_full)
  `HCW_CHECK_NEXT(a_skid_drains, skid_full && !out_stall, !skid_full)
  `HCW_CHECK_IMPL(a_bad_zero, out_valid && status, pos_r == '0 && pos_i == '0 && vel_c == '0)

endmodule
`default_nettype wire

>>> tb/tb_hcw_relative_orbit_propagator_core.sv
`timescale 1ns / 100ps
module tb_hcw_relative_orbit_propagator_core;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [47:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [47:0] time_offset;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] pos_r, pos_i, pos_c, vel_r, vel_i, vel_c;
  logic               status;

  logic [31:0] cur_motion;
  logic [47:0] cur_recip;
  longint      cur_pos[3];
  longint      cur_vel[3];

  hcwop_pkg::res_t state_q[$];
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          cfg_sets = 0;
  logic        no_idle = 1'b0;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  hcw_relative_orbit_propagator_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .time_offset(time_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_r(pos_r), .pos_i(pos_i), .pos_c(pos_c),
    .vel_r(vel_r), .vel_i(vel_i), .vel_c(vel_c), .status(status)
  );

  always #2 clk = ~clk;

  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint round_mul(input longint a, input longint b, input int sh);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    logic         neg;
    longint       r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'b0, ua} * {64'b0, ub};
    if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > (128'd1 << 56)) p = 128'd1 << 56;
    r = longint'(p[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic longint atan_step(input int i);
    longint sum, term;
    int     k;
    sum = 0;
    if (i == 0) return 843314857;
    for (k = 0; 60 - (2 * k + 1) * i >= 0; k++) begin
      term = (longint'(1) << (60 - (2 * k + 1) * i)) / longint'(2 * k + 1);
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    return (sum + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic void angle_sin_cos(input logic [31:0] n, input longint t,
                                        output longint sn, output longint cs);
    logic [159:0] prod;
    logic [31:0]  u, rv;
    logic [1:0]   qd;
    longint       z, cx, cy, dx, dy, at;
    prod = 160'(n) * 160'(t) * 160'(hcwop_pkg::INV2PI_Q64);
    u = prod[111:80];
    qd = 2'((u + 32'h2000_0000) >> 30);
    rv = u - {qd, 30'b0};
    z = round_mul(longint'(signed'(rv)), 64'sd6746518852, 32);
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      at = atan_step(i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= at;
      end else begin
        cx += dx; cy -= dy; z += at;
      end
    end
    case (qd)
      2'd0: begin cs = cx;  sn = cy;  end
      2'd1: begin cs = -cy; sn = cx;  end
      2'd2: begin cs = -cx; sn = -cy; end
      default: begin cs = cy; sn = -cx; end
    endcase
  endfunction

  function automatic logic signed [47:0] clip48(input longint v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic hcwop_pkg::res_t hcw_state_at(input logic signed [47:0] t48);
    hcwop_pkg::res_t r;
    longint t, n, rn, s, c, omc, rs, romc, ns, nomc, nt;
    longint x0, y0, z0, xd, yd, zd;
    longint v[6];
    r = '0;
    t = t48;
    if (cur_motion == 0 || t < 0) begin
      r.status = 1'b1;
      return r;
    end
    n = longint'({32'b0, cur_motion});
    rn = longint'({16'b0, cur_recip});
    x0 = cur_pos[0]; y0 = cur_pos[1]; z0 = cur_pos[2];
    xd = cur_vel[0]; yd = cur_vel[1]; zd = cur_vel[2];
    angle_sin_cos(cur_motion, t, s, c);
    omc = (longint'(1) << 30) - c;
    rs = round_mul(rn, s, 30);
    romc = round_mul(rn, omc, 30);
    ns = round_mul(n, s, 32);
    nomc = round_mul(n, omc, 32);
    nt = round_mul(n, t, 32);
    v[0] = 4 * x0 - 3 * round_mul(c, x0, 30) + round_mul(rs, xd, 16)
         + 2 * round_mul(romc, yd, 16);
    v[1] = y0 + 6 * round_mul(s, x0, 30) - 6 * round_mul(nt, x0, 16)
         - 2 * round_mul(romc, xd, 16) + 4 * round_mul(rs, yd, 16)
         - 3 * round_mul(t, yd, 16);
    v[2] = round_mul(c, z0, 30) + round_mul(rs, zd, 16);
    v[3] = 3 * round_mul(ns, x0, 30) + round_mul(c, xd, 30) + 2 * round_mul(s, yd, 30);
    v[4] = -6 * round_mul(nomc, x0, 30) - 2 * round_mul(s, xd, 30)
         + 4 * round_mul(c, yd, 30) - 3 * yd;
    v[5] = -round_mul(ns, z0, 30) + round_mul(c, zd, 30);
    r.pos_r = clip48(v[0]);
    r.pos_i = clip48(v[1]);
    r.pos_c = clip48(v[2]);
    r.vel_r = clip48(v[3]);
    r.vel_i = clip48(v[4]);
    r.vel_c = clip48(v[5]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, beats_out);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 26);
    end
  end

  always @(negedge clk) begin : result_check
    hcwop_pkg::res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (state_q.size() == 0) begin
        report_mismatch("unexpected beat", pos_r, 48'b0);
      end else begin
        w = state_q.pop_front();
        check_field("pos_r", pos_r, w.pos_r);
        check_field("pos_i", pos_i, w.pos_i);
        check_field("pos_c", pos_c, w.pos_c);
        check_field("vel_r", vel_r, w.vel_r);
        check_field("vel_i", vel_i, w.vel_i);
        check_field("vel_c", vel_c, w.vel_c);
        check_field("status", 48'(status), 48'(w.status));
      end
      beats_out++;
    end
  end

  task automatic send_time(input logic signed [47:0] t);
    logic busy;
    if (!no_idle) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    time_offset <= t;
    do begin
      @(negedge clk);
      busy = in_stall;
      @(posedge clk);
    end while (busy);
    state_q.push_back(hcw_state_at(t));
    beats_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (state_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    case (idx)
      hcwop_pkg::REG_MEAN_MOTION:  cur_motion = data[31:0];
      hcwop_pkg::REG_RECIP_MOTION: cur_recip = data;
      hcwop_pkg::REG_INIT_POS_R:   cur_pos[0] = longint'(signed'(data));
      hcwop_pkg::REG_INIT_POS_I:   cur_pos[1] = longint'(signed'(data));
      hcwop_pkg::REG_INIT_POS_C:   cur_pos[2] = longint'(signed'(data));
      hcwop_pkg::REG_INIT_VEL_R:   cur_vel[0] = longint'(signed'(data));
      hcwop_pkg::REG_INIT_VEL_I:   cur_vel[1] = longint'(signed'(data));
      default:                     cur_vel[2] = longint'(signed'(data));
    endcase
  endtask

  task automatic load_orbit(input logic [47:0] n, input logic [47:0] rn,
                            input logic [47:0] pr, input logic [47:0] pi,
                            input logic [47:0] pc, input logic [47:0] vr,
                            input logic [47:0] vi, input logic [47:0] vc);
    wait_drained();
    write_reg(hcwop_pkg::REG_MEAN_MOTION, n);
    write_reg(hcwop_pkg::REG_RECIP_MOTION, rn);
    write_reg(hcwop_pkg::REG_INIT_POS_R, pr);
    write_reg(hcwop_pkg::REG_INIT_POS_I, pi);
    write_reg(hcwop_pkg::REG_INIT_POS_C, pc);
    write_reg(hcwop_pkg::REG_INIT_VEL_R, vr);
    write_reg(hcwop_pkg::REG_INIT_VEL_I, vi);
    write_reg(hcwop_pkg::REG_INIT_VEL_C, vc);
    cfg_valid <= 1'b0;
    cfg_sets++;
  endtask

  function automatic logic [47:0] rand_state(input int meters);
    longint m;
    m = longint'($urandom_range(0, 2 * meters)) - meters;
    return 48'((m <<< 16) + longint'($urandom_range(0, 65535)));
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic load_leo_orbit();
    logic [31:0] n;
    n = $urandom_range(2000000, 9000000);
    load_orbit(48'(n), 48'((64'd1 << 48) / n), rand_state(100000), rand_state(100000),
               rand_state(100000), rand_state(200), rand_state(200), rand_state(200));
  endtask

  function automatic logic signed [47:0] rand_time();
    case ($urandom_range(9))
      0: return rand48();
      1: return -48'sd1 - 48'($urandom_range(0, 1 << 24));
      2, 3, 4, 5: return 48'({$urandom_range(0, 86400), 16'($urandom)});
      6, 7: return 48'({15'($urandom), 32'($urandom)});
      8: return {1'b0, 47'(rand48())};
      default: begin
        case ($urandom_range(3))
          0: return 48'sd0;
          1: return 48'sh7FFF_FFFF_FFFF;
          2: return -48'sd1;
          default: return 48'sh8000_0000_0000;
        endcase
      end
    endcase
  endfunction

  task automatic test_reset_values();
    send_time(48'sd0);
    send_time(48'sd65536);
    send_time(-48'sd1);
  endtask

  task automatic test_directed();
    load_leo_orbit();
    send_time(48'sd0);
    send_time(48'sd1);
    send_time(48'sd65536);
    send_time(48'sh7FFF_FFFF_FFFF);
    send_time(-48'sd1);
    send_time(48'sh8000_0000_0000);
    send_time(48'sd377_487_360);
    load_orbit(48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
               48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    send_time(48'sd0);
    send_time(48'sh7FFF_FFFF_FFFF);
    send_time(48'sd1234567);
    load_orbit(48'd1, 48'h0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
               48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
    send_time(48'sh7FFF_FFFF_FFFF);
    send_time(48'sd65536);
    load_orbit(48'hFFFF_0000_0000, rand48(), rand_state(1000), rand_state(1000),
               rand_state(1000), rand_state(10), rand_state(10), rand_state(10));
    send_time(48'sd65536);
    send_time(48'sd0);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) begin
        load_orbit(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
                   rand48());
      end else begin
        load_leo_orbit();
      end
      no_idle = (ph == 3);
      for (int k = 0; k < 215; k++) send_time(rand_time());
      no_idle = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    load_leo_orbit();
    hold_tog <= ~hold_tog;
    for (int k = 0; k < 150; k++) send_time(rand_time());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = hcwop_pkg::REG_MEAN_MOTION;
    cfg_data = '0;
    in_valid = 1'b0;
    time_offset = '0;
    cur_motion = '0;
    cur_recip = '0;
    for (int i = 0; i < 3; i++) begin
      cur_pos[i] = 0;
      cur_vel[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_drained();
    $display("Sent %0d time offsets, checked %0d state beats over %0d orbit settings,",
             beats_in, beats_out, cfg_sets);
    $display("with random stalls, a long output hold-off and an idle-free stretch.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
